>>> hw/rtl/arpsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpsc_pkg
// Shared types and constants for the ARP binding spoof check block.
// ----------------------------------------------------------------------------
package arpsc_pkg;

   // Binding table geometry
   localparam int TABLE_DEPTH = 2048;
   localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int IP_W    = 32;
   localparam int MAC_W   = 48;
   localparam int ENTRY_W = IP_W + MAC_W;

   // Configuration registers
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_LOW  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_HIGH = 1'b1;

   localparam logic [IP_W-1:0] RANGE_LOW_RESET  = 32'hC0A8_0000;
   localparam logic [IP_W-1:0] RANGE_HIGH_RESET = 32'hC0A8_FFFF;

   // Item kind
   localparam logic ACT_CHECK = 1'b0;
   localparam logic ACT_LOAD  = 1'b1;

   typedef enum logic [2:0] {
      STAT_VALID  = 3'd0,
      STAT_SPOOF  = 3'd1,
      STAT_NEW    = 3'd2,
      STAT_RANGE  = 3'd3,
      STAT_FULL   = 3'd4,
      STAT_LOADED = 3'd5
   } status_type;

   typedef struct packed {
      logic [MAC_W-1:0] mac;
      logic [IP_W-1:0]  ip;
   } entry_type;

   typedef struct packed {
      status_type       status;
      logic [MAC_W-1:0] stored_mac;
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } seq_state_type;

endpackage

>>> hw/rtl/arpsc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpsc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module arpsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/arpsc_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpsc_seq
// Sequencer and shared compare unit: range check, linear table search, append.
// ----------------------------------------------------------------------------
module arpsc_seq import arpsc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   // item handoff
   input  logic                start,
   input  logic                req_action,
   input  logic [IP_W-1:0]     req_ip,
   input  logic [MAC_W-1:0]    req_mac,
   output logic                idle,
   // window
   input  logic [IP_W-1:0]     range_low,
   input  logic [IP_W-1:0]     range_high,
   // result handoff
   input  logic                out_free,
   output logic                done,
   output result_type          result,
   // table RAM
   output logic                ram_we,
   output logic [ADDR_W-1:0]   ram_waddr,
   output logic [ENTRY_W-1:0]  ram_wdata,
   output logic [ADDR_W-1:0]   ram_raddr,
   input  logic [ENTRY_W-1:0]  ram_rdata
);

   seq_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              pend_ff, pend_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IP_W-1:0]   ip_ff, ip_in;
   logic [MAC_W-1:0]  mac_ff, mac_in;
   result_type        res_ff, res_in;

   entry_type         wr_entry;
   entry_type         rd_entry;
   logic              has_room;
   logic              in_range;
   logic              issue;
   logic              ip_hit;

   assign has_room = count_ff < CNT_W'(TABLE_DEPTH);
   assign in_range = !(req_ip < range_low) && !(req_ip > range_high);
   assign issue    = idx_ff < count_ff;
   assign rd_entry = entry_type'(ram_rdata);
   // shared compare unit: one stored IP against the item IP per cycle
   assign ip_hit   = pend_ff && (rd_entry.ip == ip_ff);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      pend_in  = pend_ff;
      count_in = count_ff;
      ip_in    = ip_ff;
      mac_in   = mac_ff;
      res_in   = res_ff;
      ram_we   = 1'b0;
      wr_entry = '{mac: req_mac, ip: req_ip};
      done     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               res_in.stored_mac = '0;
               if (req_action == ACT_LOAD) begin
                  if (has_room) begin
                     ram_we        = 1'b1;
                     count_in      = count_ff + 1'b1;
                     res_in.status = STAT_LOADED;
                  end else begin
                     res_in.status = STAT_FULL;
                  end
                  state_in = ST_DONE;
               end else if (!in_range) begin
                  res_in.status = STAT_RANGE;
                  state_in      = ST_DONE;
               end else begin
                  ip_in    = req_ip;
                  mac_in   = req_mac;
                  idx_in   = '0;
                  pend_in  = 1'b0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            wr_entry = '{mac: mac_ff, ip: ip_ff};
            if (ip_hit) begin
               res_in.stored_mac = rd_entry.mac;
               res_in.status     = (rd_entry.mac == mac_ff) ? STAT_VALID : STAT_SPOOF;
               state_in          = ST_DONE;
            end else if (!pend_ff && !issue) begin
               // search exhausted: append as a new binding if the table has room
               res_in.stored_mac = '0;
               if (has_room) begin
                  ram_we        = 1'b1;
                  count_in      = count_ff + 1'b1;
                  res_in.status = STAT_NEW;
               end else begin
                  res_in.status = STAT_FULL;
               end
               state_in = ST_DONE;
            end else begin
               pend_in = issue;
               if (issue) begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_DONE: begin
            done = out_free;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         pend_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         pend_ff  <= pend_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      ip_ff  <= ip_in;
      mac_ff <= mac_in;
      res_ff <= res_in;
   end

   assign idle      = (state_ff == ST_IDLE);
   assign result    = res_ff;
   assign ram_waddr = count_ff[ADDR_W-1:0];
   assign ram_wdata = wr_entry;
   assign ram_raddr = idx_ff[ADDR_W-1:0];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_write_room: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> has_room)
      else $error("table write with no room");

   a_write_count: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> count_ff == $past(count_ff) + 1'b1)
      else $error("entry count did not advance on append");

   a_read_below: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> idx_ff <= count_ff && idx_ff != '0)
      else $error("compare of an entry at or above the count");

endmodule

>>> hw/rtl/arp_binding_spoof_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_binding_spoof_check
// Binding table of IPv4-to-MAC pairs checked against ARP sender pairs.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake            Payload
//  req_     in   tvalid/tready        tuser: action; tdata: sender_ip, sender_mac
//  rsp_     out  tvalid/tready        tuser: status; tdata: stored_mac
//  csr_     in   we (no wait)         index 0 range_low, 1 range_high
//
//  A load or out-of-range item goes from the idle state straight to the done
//  state and its result. A check item that searches the table stops at the
//  first entry whose IP matches, and appends the item as a new binding on a miss: the
//  search reads one stored binding per cycle through the single read port of
//  the table RAM.
//  Reset clears the entry count and loads the window registers with their reset values; the table contents
//  are never compared at or above the count, so no clearing pass runs.
//  The result sits in an output register, so a new item transfers while an
//  earlier result waits for rsp_tready; the search itself blocks req_tready.
// ----------------------------------------------------------------------------
module arp_binding_spoof_check import arpsc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // request stream
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [79:0]          req_tdata,   // [31:0] sender_ip, [79:32] sender_mac
   input  logic [0:0]           req_tuser,   // [0] action
   // response stream
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [47:0]          rsp_tdata,   // [47:0] stored_mac
   output logic [2:0]           rsp_tuser,   // [2:0] status
   // configuration writes
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [IP_W-1:0]      csr_wdata
);

   logic [IP_W-1:0]    range_low_ff;
   logic [IP_W-1:0]    range_high_ff;

   logic               seq_idle;
   logic               start;
   logic               done;
   logic               out_free;
   result_type         result;

   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_data_ff, rsp_data_in;

   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic [ADDR_W-1:0]  ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;

   // Window registers: take every write, ignore indexes past the list.
   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= RANGE_LOW_RESET;
         range_high_ff <= RANGE_HIGH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RANGE_LOW:  range_low_ff  <= csr_wdata;
            CSR_RANGE_HIGH: range_high_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Accept a transfer only while the sequencer idles.
   assign req_tready = seq_idle;
   assign start      = req_tvalid && seq_idle;

   // Output register is free when empty or drained this cycle.
   assign out_free = !rsp_valid_ff || rsp_tready;

   arpsc_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_tuser[0]),
      .req_ip     (req_tdata[31:0]),
      .req_mac    (req_tdata[79:32]),
      .idle       (seq_idle),
      .range_low  (range_low_ff),
      .range_high (range_high_ff),
      .out_free   (out_free),
      .done       (done),
      .result     (result),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata)
   );

   arpsc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Load the result on done, drop the valid once the transfer completes.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff.stored_mac;
   assign rsp_tuser  = rsp_data_ff.status;

endmodule
